// ===== hdl/x86alu_pkg.sv =====
// ----------------------------------------------------------------------------
// x86alu_pkg
// shared types and operation codes for the 16-bit x86-style alu
// ----------------------------------------------------------------------------
package x86alu_pkg;

    localparam int DataW = 16;
    localparam int ByteW = 8;
    localparam int ActW  = 5;
    localparam int CntW  = 8;
    localparam int StepW = 5;

    localparam logic [ActW-1:0] ACT_ADD  = 5'd0;
    localparam logic [ActW-1:0] ACT_ADC  = 5'd1;
    localparam logic [ActW-1:0] ACT_SUB  = 5'd2;
    localparam logic [ActW-1:0] ACT_SBB  = 5'd3;
    localparam logic [ActW-1:0] ACT_INC  = 5'd4;
    localparam logic [ActW-1:0] ACT_DEC  = 5'd5;
    localparam logic [ActW-1:0] ACT_NEG  = 5'd6;
    localparam logic [ActW-1:0] ACT_AND  = 5'd7;
    localparam logic [ActW-1:0] ACT_OR   = 5'd8;
    localparam logic [ActW-1:0] ACT_XOR  = 5'd9;
    localparam logic [ActW-1:0] ACT_CMC  = 5'd10;
    localparam logic [ActW-1:0] ACT_ROL  = 5'd11;
    localparam logic [ActW-1:0] ACT_ROR  = 5'd12;
    localparam logic [ActW-1:0] ACT_RCL  = 5'd13;
    localparam logic [ActW-1:0] ACT_RCR  = 5'd14;
    localparam logic [ActW-1:0] ACT_SHL  = 5'd15;
    localparam logic [ActW-1:0] ACT_SHR  = 5'd16;
    localparam logic [ActW-1:0] ACT_SAR  = 5'd17;
    localparam logic [ActW-1:0] ACT_MUL  = 5'd18;
    localparam logic [ActW-1:0] ACT_IMUL = 5'd19;
    localparam logic [ActW-1:0] ACT_DIV  = 5'd20;

    typedef struct packed {
        logic [ActW-1:0]  action;
        logic             wide;
        logic             signed_divide;
        logic [DataW-1:0] dest_value;
        logic [DataW-1:0] src_value;
        logic [CntW-1:0]  shift_count;
        logic [DataW-1:0] ax_in;
        logic [DataW-1:0] dx_in;
        logic             carry_in;
        logic             overflow_in;
    } t_req;

    typedef struct packed {
        logic [DataW-1:0] result_low;
        logic [DataW-1:0] result_high;
        logic             carry_out;
        logic             overflow_out;
        logic             divide_error;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic [StepW-1:0] steps;
    } t_stat;

endpackage

// ===== hdl/x86alu_if.sv =====
// ----------------------------------------------------------------------------
// x86alu_if
// valid/ready channels carrying alu requests and responses
// ----------------------------------------------------------------------------
interface x86alu_req_if;
    import x86alu_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface x86alu_rsp_if;
    import x86alu_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/x86_16bit_alu_unit.sv =====
// ----------------------------------------------------------------------------
// x86_16bit_alu_unit
// 8086-style alu: arithmetic, logic, shifts, rotates, multiply and divide
// ----------------------------------------------------------------------------
// One request is handled at a time. A request is loaded, then iterates as
// often as the operation needs, then completes: the simple arithmetic, logic,
// cmc and multiply operations do not iterate, shifts and rotates iterate for
// their reduced count (at most 17 iterations of the one-bit shifter), and
// divides for 8 or 16 steps of the restoring divider, which yields one
// quotient bit per cycle; a zero divisor or an unsigned quotient overflow is
// caught at load and the divide then does not iterate. The
// response is held in an output register, so the next request is taken while
// it waits.
module x86_16bit_alu_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    x86alu_req_if.sink    i_req,
    x86alu_rsp_if.source  o_rsp
);
    import x86alu_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    x86alu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    x86alu_dp u_dp (
        .i_clk  (i_clk),
        .i_req  (i_req.data),
        .i_cmd  (w_cmd),
        .o_stat (w_stat),
        .o_rsp  (o_rsp.data)
    );

endmodule

// ===== hdl/x86alu_ctrl.sv =====
// ----------------------------------------------------------------------------
// x86alu_ctrl
// sequences load, iteration and completion of one request
// ----------------------------------------------------------------------------
module x86alu_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_ready,
    output logic                o_rsp_valid,
    input  logic                i_rsp_ready,
    input  x86alu_pkg::t_stat   i_stat,
    output x86alu_pkg::t_cmd    o_cmd
);
    import x86alu_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [StepW-1:0] r_cnt, n_cnt;
    logic             r_valid, n_valid;
    logic             w_slot_free;

    assign o_req_ready = (r_state == ST_IDLE);
    assign o_rsp_valid = r_valid;
    assign w_slot_free = !r_valid || i_rsp_ready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_cnt == i_stat.steps) begin
                    n_state = ST_FIN;
                end else begin
                    o_cmd.step = 1'b1;
                    n_cnt      = r_cnt + StepW'(1);
                end
            end
            ST_FIN: begin
                if (w_slot_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (r_valid && i_rsp_ready) n_valid = 1'b0;
        if (o_cmd.finish) n_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

endmodule

// ===== hdl/x86alu_dp.sv =====
// ----------------------------------------------------------------------------
// x86alu_dp
// operand registers, one-bit shifter, multiplier and restoring divider
// ----------------------------------------------------------------------------
module x86alu_dp (
    input  logic                i_clk,
    input  x86alu_pkg::t_req    i_req,
    input  x86alu_pkg::t_cmd    i_cmd,
    output x86alu_pkg::t_stat   o_stat,
    output x86alu_pkg::t_rsp    o_rsp
);
    import x86alu_pkg::*;

    function automatic logic [StepW-1:0] mod9(input logic [CntW-1:0] c);
        logic [5:0] x;
        x = 6'd36 + {2'b0, c[3:0]} - {1'b0, c[7:4], 1'b0};
        for (int k = 0; k < 5; k++) begin
            if (x >= 6'd9) x = x - 6'd9;
        end
        return x[StepW-1:0];
    endfunction

    function automatic logic [StepW-1:0] mod17(input logic [CntW-1:0] c);
        logic [5:0] x;
        x = 6'd17 + {2'b0, c[3:0]} - {2'b0, c[7:4]};
        if (x >= 6'd17) x = x - 6'd17;
        return x[StepW-1:0];
    endfunction

    // request registers
    logic [ActW-1:0]  r_act;
    logic             r_wide, r_sdiv, r_cnt1;
    logic [DataW-1:0] r_ax, r_dx;
    logic             r_cf, r_of;
    // working registers
    logic [DataW-1:0] r_d;
    logic [StepW-1:0] r_steps;
    logic [31:0]      r_prod;
    logic [DataW:0]   r_rem;
    logic [DataW-1:0] r_quo, r_dvs;
    logic             r_nneg, r_dneg, r_err;
    t_rsp             r_rsp;

    // load-side signals
    logic [DataW-1:0] w_mask, w_d, w_s, w_a, w_alu;
    logic             w_cf, w_of;
    logic [StepW-1:0] w_steps, w_bits, w_rot;
    logic signed [16:0] w_ma, w_ms;
    logic signed [33:0] w_p;
    logic [31:0]      w_n32, w_nmag;
    logic [DataW-1:0] w_ax_neg, w_smag, w_hi, w_lo;
    logic             w_nneg, w_sneg, w_lerr;

    always_comb begin
        w_mask = i_req.wide ? 16'hFFFF : 16'h00FF;
        w_d    = i_req.dest_value & w_mask;
        w_s    = i_req.src_value & w_mask;
        w_a    = i_req.ax_in & w_mask;
        w_bits = i_req.wide ? StepW'(16) : StepW'(8);
        w_cf   = i_req.carry_in;
        w_of   = i_req.overflow_in;
        w_alu  = '0;
        case (i_req.action)
            ACT_ADD: w_alu = w_d + w_s;
            ACT_ADC: w_alu = w_d + w_s + {15'b0, i_req.carry_in};
            ACT_SUB: w_alu = w_d - w_s;
            ACT_SBB: w_alu = w_d - w_s - {15'b0, i_req.carry_in};
            ACT_INC: w_alu = w_d + 16'd1;
            ACT_DEC: w_alu = w_d - 16'd1;
            ACT_NEG: w_alu = 16'd0 - w_d;
            ACT_AND: begin w_alu = w_d & w_s; w_cf = 1'b0; w_of = 1'b0; end
            ACT_OR:  begin w_alu = w_d | w_s; w_cf = 1'b0; w_of = 1'b0; end
            ACT_XOR: begin w_alu = w_d ^ w_s; w_cf = 1'b0; w_of = 1'b0; end
            ACT_CMC: w_cf = !i_req.carry_in;
            ACT_ROL, ACT_ROR, ACT_RCL, ACT_RCR, ACT_SHL, ACT_SHR, ACT_SAR: w_alu = w_d;
            default: w_alu = '0;
        endcase
        w_alu = w_alu & w_mask;

        // iteration count
        w_rot = i_req.wide ? {1'b0, i_req.shift_count[3:0]}
                           : {2'b0, i_req.shift_count[2:0]};
        if (w_rot == '0 && i_req.shift_count != '0) w_rot = w_bits;
        w_steps = '0;
        case (i_req.action)
            ACT_ROL, ACT_ROR: w_steps = w_rot;
            ACT_RCL, ACT_RCR: w_steps = i_req.wide ? mod17(i_req.shift_count)
                                                   : mod9(i_req.shift_count);
            ACT_SHL, ACT_SHR, ACT_SAR:
                w_steps = (i_req.shift_count > CntW'(w_bits + StepW'(1)))
                        ? w_bits + StepW'(1) : i_req.shift_count[StepW-1:0];
            default: w_steps = '0;
        endcase

        // shared signed multiplier, zero extension for mul
        if (i_req.action == ACT_IMUL) begin
            w_ma = i_req.wide ? {w_a[15], w_a} : {{9{w_a[7]}}, w_a[7:0]};
            w_ms = i_req.wide ? {w_s[15], w_s} : {{9{w_s[7]}}, w_s[7:0]};
        end else begin
            w_ma = {1'b0, w_a};
            w_ms = {1'b0, w_s};
        end
        w_p = w_ma * w_ms;

        // divide set-up on magnitudes
        w_n32    = {i_req.dx_in, i_req.ax_in};
        w_ax_neg = 16'd0 - i_req.ax_in;
        w_nneg   = i_req.signed_divide && (i_req.wide ? i_req.dx_in[15] : i_req.ax_in[15]);
        w_sneg   = i_req.signed_divide && (i_req.wide ? w_s[15] : w_s[7]);
        if (i_req.wide) w_nmag = w_nneg ? 32'd0 - w_n32 : w_n32;
        else            w_nmag = {16'b0, w_nneg ? w_ax_neg : i_req.ax_in};
        w_smag = w_sneg ? ((16'd0 - w_s) & w_mask) : w_s;
        w_hi   = i_req.wide ? w_nmag[31:16] : {8'b0, w_nmag[15:8]};
        w_lo   = i_req.wide ? w_nmag[15:0] : {w_nmag[7:0], 8'b0};
        w_lerr = (w_s == '0) || (w_hi >= w_smag);
        if (i_req.action == ACT_DIV && !w_lerr) w_steps = w_bits;
    end

    // one iteration
    logic [DataW-1:0] w_top, w_smask, w_sd;
    logic             w_msb, w_scf;
    logic [DataW:0]   w_rem2;
    logic             w_qbit;

    always_comb begin
        w_smask = r_wide ? 16'hFFFF : 16'h00FF;
        w_top   = r_wide ? 16'h8000 : 16'h0080;
        w_msb   = r_wide ? r_d[15] : r_d[7];
        w_sd    = r_d;
        w_scf   = r_cf;
        case (r_act)
            ACT_ROL: begin w_scf = w_msb; w_sd = ((r_d << 1) | {15'b0, w_msb}) & w_smask; end
            ACT_ROR: begin w_scf = r_d[0]; w_sd = (r_d >> 1) | (r_d[0] ? w_top : 16'd0); end
            ACT_RCL: begin w_scf = w_msb; w_sd = ((r_d << 1) | {15'b0, r_cf}) & w_smask; end
            ACT_RCR: begin w_scf = r_d[0]; w_sd = (r_d >> 1) | (r_cf ? w_top : 16'd0); end
            ACT_SHL: begin w_scf = w_msb; w_sd = (r_d << 1) & w_smask; end
            ACT_SHR: begin w_scf = r_d[0]; w_sd = r_d >> 1; end
            ACT_SAR: begin w_scf = r_d[0]; w_sd = (r_d >> 1) | (r_d & w_top); end
            default: ;
        endcase
        w_rem2 = {r_rem[DataW-1:0], r_quo[DataW-1]};
        w_qbit = (w_rem2 >= {1'b0, r_dvs});
    end

    // completion
    logic [DataW-1:0] w_q, w_r, w_sq, w_sr, w_ph;
    logic             w_derr, w_mflag;
    t_rsp             w_rsp;

    always_comb begin
        w_q    = r_wide ? r_quo : {8'b0, r_quo[7:0]};
        w_r    = r_rem[DataW-1:0];
        w_derr = r_err || (r_sdiv && (w_q > ((r_wide ? 16'h8000 : 16'h0080) - 16'd1)));
        w_sq   = ((r_nneg ^ r_dneg) ? 16'd0 - w_q : w_q) & (r_wide ? 16'hFFFF : 16'h00FF);
        w_sr   = (r_nneg ? 16'd0 - w_r : w_r) & (r_wide ? 16'hFFFF : 16'h00FF);
        w_ph   = r_wide ? r_prod[31:16] : {8'b0, r_prod[15:8]};
        if (r_act == ACT_IMUL)
            w_mflag = (w_ph != ((r_wide ? r_prod[15] : r_prod[7]) ? w_smask : 16'd0));
        else
            w_mflag = (w_ph != 16'd0);

        w_rsp.result_low   = r_d;
        w_rsp.result_high  = r_dx;
        w_rsp.carry_out    = r_cf;
        w_rsp.overflow_out = r_of;
        w_rsp.divide_error = 1'b0;
        case (r_act)
            ACT_RCL: if (r_cnt1) w_rsp.overflow_out = w_msb ^ r_cf;
            ACT_RCR: if (r_cnt1) w_rsp.overflow_out = r_wide ? r_d[15] ^ r_d[14]
                                                             : r_d[7] ^ r_d[6];
            ACT_MUL, ACT_IMUL: begin
                w_rsp.result_low   = r_prod[15:0];
                w_rsp.result_high  = r_wide ? r_prod[31:16] : r_dx;
                w_rsp.carry_out    = w_mflag;
                w_rsp.overflow_out = w_mflag;
            end
            ACT_DIV: begin
                if (w_derr) begin
                    w_rsp.result_low   = r_ax;
                    w_rsp.divide_error = 1'b1;
                end else if (r_wide) begin
                    w_rsp.result_low  = w_sq;
                    w_rsp.result_high = w_sr;
                end else begin
                    w_rsp.result_low = {w_sr[7:0], w_sq[7:0]};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act   <= i_req.action;
            r_wide  <= i_req.wide;
            r_sdiv  <= i_req.signed_divide;
            r_cnt1  <= (i_req.shift_count == CntW'(1));
            r_ax    <= i_req.ax_in;
            r_dx    <= i_req.dx_in;
            r_cf    <= w_cf;
            r_of    <= w_of;
            r_d     <= w_alu;
            r_steps <= w_steps;
            r_prod  <= w_p[31:0];
            r_rem   <= {1'b0, w_hi};
            r_quo   <= w_lo;
            r_dvs   <= w_smag;
            r_nneg  <= w_nneg;
            r_dneg  <= w_sneg;
            r_err   <= w_lerr;
        end else if (i_cmd.step) begin
            if (r_act == ACT_DIV) begin
                r_rem <= w_qbit ? w_rem2 - {1'b0, r_dvs} : w_rem2;
                r_quo <= {r_quo[DataW-2:0], w_qbit};
            end else begin
                r_d  <= w_sd;
                r_cf <= w_scf;
            end
        end
        if (i_cmd.finish) r_rsp <= w_rsp;
    end

    assign o_stat.steps = r_steps;
    assign o_rsp        = r_rsp;

endmodule

// ===== sim/tb_x86_16bit_alu_unit.sv =====
// ----------------------------------------------------------------------------
// tb_x86_16bit_alu_unit
// checks every alu operation in both widths against a predictor of its own
// ----------------------------------------------------------------------------
// A directed set of requests covers the field extremes, every action code and
// the divide error cases. Random requests follow, with random gaps on the
// request side and random stalls on the response side. Each response is
// compared field by field with the oldest predicted response.
// ----------------------------------------------------------------------------
class alu_scoreboard;
    x86alu_pkg::t_rsp pending[$];
    int               mismatches;
    int               checked;
    int               div_errors;

    function logic [16:0] sx(logic [15:0] v, bit w);
        int r;
        r = w ? int'($signed(v)) : int'($signed(v[7:0]));
        return 17'(r);
    endfunction

    function x86alu_pkg::t_rsp alu_predict(x86alu_pkg::t_req q);
        x86alu_pkg::t_rsp r;
        logic [15:0] mask, top, d, s, lo, hi, pl, ph;
        logic [31:0] p, dividend, qu, rm;
        logic cf, of, err, b;
        longint n, v, sq, sr, lim;
        mask = q.wide ? 16'hFFFF : 16'h00FF;
        top  = q.wide ? 16'h8000 : 16'h0080;
        d = q.dest_value & mask;
        s = q.src_value & mask;
        cf = q.carry_in;
        of = q.overflow_in;
        lo = '0;
        hi = q.dx_in;
        err = 1'b0;
        case (q.action)
            x86alu_pkg::ACT_ADD: lo = d + s;
            x86alu_pkg::ACT_ADC: lo = d + s + 16'(cf);
            x86alu_pkg::ACT_SUB: lo = d - s;
            x86alu_pkg::ACT_SBB: lo = d - s - 16'(cf);
            x86alu_pkg::ACT_INC: lo = d + 1;
            x86alu_pkg::ACT_DEC: lo = d - 1;
            x86alu_pkg::ACT_NEG: lo = 16'd0 - d;
            x86alu_pkg::ACT_AND: begin lo = d & s; cf = 0; of = 0; end
            x86alu_pkg::ACT_OR:  begin lo = d | s; cf = 0; of = 0; end
            x86alu_pkg::ACT_XOR: begin lo = d ^ s; cf = 0; of = 0; end
            x86alu_pkg::ACT_CMC: begin cf = ~cf; lo = 0; end
            x86alu_pkg::ACT_ROL, x86alu_pkg::ACT_ROR, x86alu_pkg::ACT_RCL,
            x86alu_pkg::ACT_RCR, x86alu_pkg::ACT_SHL, x86alu_pkg::ACT_SHR,
            x86alu_pkg::ACT_SAR: begin
                logic [15:0] sgn;
                sgn = d & top;
                for (int i = 0; i < q.shift_count; i++) begin
                    case (q.action)
                        x86alu_pkg::ACT_ROL: begin
                            cf = |(d & top); d = ((d << 1) | 16'(cf)) & mask;
                        end
                        x86alu_pkg::ACT_ROR: begin
                            cf = d[0]; d = (d >> 1) | (cf ? top : 16'd0);
                        end
                        x86alu_pkg::ACT_RCL: begin
                            b = |(d & top); d = ((d << 1) | 16'(cf)) & mask; cf = b;
                        end
                        x86alu_pkg::ACT_RCR: begin
                            b = d[0]; d = (d >> 1) | (cf ? top : 16'd0); cf = b;
                        end
                        x86alu_pkg::ACT_SHL: begin
                            cf = |(d & top); d = (d << 1) & mask;
                        end
                        x86alu_pkg::ACT_SHR: begin cf = d[0]; d = d >> 1; end
                        default: begin cf = d[0]; d = (d >> 1) | sgn; end
                    endcase
                end
                if (q.shift_count == 1 && q.action == x86alu_pkg::ACT_RCL)
                    of = (|(d & top)) ^ cf;
                if (q.shift_count == 1 && q.action == x86alu_pkg::ACT_RCR)
                    of = q.wide ? d[15] ^ d[14] : d[7] ^ d[6];
                lo = d;
            end
            x86alu_pkg::ACT_MUL, x86alu_pkg::ACT_IMUL: begin
                if (q.action == x86alu_pkg::ACT_MUL)
                    p = 32'(q.ax_in & mask) * 32'(s);
                else
                    p = 32'($signed(sx(q.ax_in, q.wide)) * $signed(sx(s, q.wide)));
                pl = 16'(p) & mask;
                ph = 16'(q.wide ? p >> 16 : p >> 8) & mask;
                if (q.action == x86alu_pkg::ACT_MUL) cf = ph != 0;
                else cf = ph != ((pl & top) != 0 ? mask : 16'd0);
                of = cf;
                if (q.wide) begin lo = pl; hi = ph; end
                else lo = p[15:0];
            end
            x86alu_pkg::ACT_DIV: begin
                dividend = q.wide ? {q.dx_in, q.ax_in} : {16'd0, q.ax_in};
                qu = 0;
                rm = 0;
                if (s == 0) begin
                    err = 1;
                end else if (!q.signed_divide) begin
                    qu = dividend / s;
                    rm = dividend % s;
                    if (qu > mask) err = 1;
                end else begin
                    n = q.wide ? longint'($signed(dividend))
                               : longint'($signed(dividend[15:0]));
                    v = longint'($signed(sx(s, q.wide)));
                    sq = n / v;
                    sr = n % v;
                    lim = longint'(top) - 1;
                    if (sq > lim || sq < -lim) err = 1;
                    qu = 32'(sq) & mask;
                    rm = 32'(sr) & mask;
                end
                if (err) begin lo = q.ax_in; hi = q.dx_in; end
                else if (q.wide) begin lo = qu[15:0]; hi = rm[15:0]; end
                else lo = {rm[7:0], qu[7:0]};
            end
            default: lo = 0;
        endcase
        if (q.action <= x86alu_pkg::ACT_SAR) lo = lo & mask;
        r.result_low = lo;
        r.result_high = hi;
        r.carry_out = cf;
        r.overflow_out = of;
        r.divide_error = err;
        return r;
    endfunction

    function void note_request(x86alu_pkg::t_req q);
        pending.push_back(alu_predict(q));
    endfunction

    function void check_response(x86alu_pkg::t_rsp got);
        x86alu_pkg::t_rsp want;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", got);
            return;
        end
        want = pending.pop_front();
        checked++;
        if (got.divide_error) div_errors++;
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
    endfunction
endclass

module tb_x86_16bit_alu_unit;
    import x86alu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   cycles = 0;
    bit   stall_long = 1'b0;
    bit   stim_done = 1'b0;
    alu_scoreboard sb = new();

    x86alu_req_if req_ch();
    x86alu_rsp_if rsp_ch();

    x86_16bit_alu_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("timeout");
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && req_ch.valid && req_ch.ready) sb.note_request(req_ch.data);
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) sb.check_response(rsp_ch.data);
    end

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    endfunction

    // response side stalls
    initial begin
        rsp_ch.ready = 1'b0;
        @(negedge i_clk);
        while (1) begin
            if (stall_long) begin
                rsp_ch.ready <= 1'b0;
                repeat (200) @(negedge i_clk);
                stall_long = 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap_len()) @(negedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    task automatic send_request(t_req q, int gap);
        req_ch.data <= q;
        req_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    function automatic t_req random_fill();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return raw[$bits(t_req)-1:0];
    endfunction

    function automatic t_req random_request();
        t_req q;
        q = random_fill();
        q.action = 5'($urandom_range(0, 24));
        if ($urandom_range(0, 3) != 0) q.shift_count = 8'($urandom_range(0, 20));
        if (q.action == ACT_DIV && $urandom_range(0, 2) != 0) begin
            // mostly divides that fit
            if (q.wide) q.dx_in = q.src_value[15] ? 16'hFFFF : 16'h0000;
            else q.ax_in[15:8] = 8'($urandom_range(0, 3));
        end
        return q;
    endfunction

    task automatic directed_set();
        t_req q;
        logic [ActW-1:0] acts[$] = '{ACT_ADD, ACT_ADC, ACT_SUB, ACT_SBB, ACT_INC, ACT_DEC,
            ACT_NEG, ACT_AND, ACT_OR, ACT_XOR, ACT_CMC, ACT_ROL, ACT_ROR, ACT_RCL,
            ACT_RCR, ACT_SHL, ACT_SHR, ACT_SAR, ACT_MUL, ACT_IMUL, ACT_DIV, 5'd31};
        foreach (acts[k]) begin
            q = random_fill();
            q.action = acts[k];
            q.shift_count = (k % 3 == 0) ? 8'd255 : 8'(k % 3);
            if (k % 2 == 0) begin q.dest_value = 16'hFFFF; q.src_value = 16'hFFFF; end
            send_request(q, 0);
        end
        q = '0; q.action = ACT_DIV; q.wide = 1; q.ax_in = 16'h1234;
        send_request(q, 1);
        q.src_value = 16'h0001; q.dx_in = 16'h0001;
        send_request(q, 0);
        q = '0; q.action = ACT_DIV; q.signed_divide = 1; q.ax_in = 16'h8000;
        q.src_value = 16'h00FF;
        send_request(q, 0);
    endtask

    initial begin
        t_req q;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        directed_set();
        for (int n = 0; n < 600; n++) begin
            q = random_request();
            if (n == 200) stall_long = 1'b1;
            if (n == 400) begin
                req_ch.valid <= 1'b0;
                while (sb.pending.size() != 0) @(negedge i_clk);
            end
            send_request(q, (n > 200 && n < 260) ? 0 : gap_len());
        end
        req_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        $display("checked %0d responses, %0d of them divide errors, over all actions",
                 sb.checked, sb.div_errors);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
